// ===== rtl/tfst_pkg.sv =====
package tfst_pkg;

    localparam int NUM_SETS = 1024;
    localparam int NUM_WAYS = 4;
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

    localparam logic [7:0] FL_FIN    = 8'h01;
    localparam logic [7:0] FL_SYN    = 8'h02;
    localparam logic [7:0] FL_RST    = 8'h04;
    localparam logic [7:0] FL_ACK    = 8'h10;
    localparam logic [7:0] FL_SYNACK = 8'h12;
    localparam logic [7:0] PERFECT_MIN = 8'hef;
    localparam logic [7:0] STATE_NEW   = 8'h80;

    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_CREATED  = 3'd1;
    localparam logic [2:0] ST_IGNORED  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_FOUND    = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;
    localparam logic [2:0] ST_DELETED  = 3'd6;

    // one stored flow record (valid bit lives elsewhere)
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] src_seq;
        logic [31:0] dst_seq;
        logic [15:0] last_len;
        logic [7:0]  last_flags;
        logic [7:0]  life;
        logic [31:0] hits;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== rtl/tfst_way_ram.sv =====
// One way of the flow table: 1 write port, 1 registered read port.
module tfst_way_ram
    import tfst_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [SET_W-1:0]   i_waddr,
    input  t_entry             i_wdata,
    input  logic [SET_W-1:0]   i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [NUM_SETS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/tcp_flow_state_tracker_top.sv =====
// TCP flow state tracker. Each request (packet update, query or delete) is
// handled thus: on acceptance all ways of the set chosen by
// (key ^ key>>16) mod NUM_SETS are read from the per-way memories and the
// valid memory; in S_EXEC keys are compared, the update is computed and the
// touched way, if any, and on a create or delete the valid word are written
// back; the next request is accepted only after that write, so no forwarding
// is needed. A result waits in an output register, and a request is accepted
// only while that register is empty or being read in the same cycle, so a
// stalled output delays the next request. A clearing pass after reset zeroes
// all NUM_SETS (1024) valid words; no request is accepted before it ends.
module tcp_flow_state_tracker_top
    import tfst_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] command, [33:2] flow_key, [65:34] seq_num, [97:66] ack_num,
    // [105:98] tcp_flags, [121:106] payload_len, [127:122] zero
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status, [10:3] flow_state, [11] perfect, [43:12] hit_count,
    // [47:44] zero
    output logic [47:0]  m_axis_tdata
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [1:0]  r_cmd;
    logic [31:0] r_key, r_seq, r_ack;
    logic [7:0]  r_fl;
    logic [15:0] r_len;
    logic [SET_W-1:0] r_set;
    logic [SET_W-1:0] r_clr;

    // valid bits, one word per set
    logic [NUM_WAYS-1:0] r_vmem [NUM_SETS];
    logic [NUM_WAYS-1:0] r_vrd;
    logic                vwe;
    logic [SET_W-1:0]    vwaddr;
    logic [NUM_WAYS-1:0] vwdata;

    t_entry rd [NUM_WAYS];
    logic   we [NUM_WAYS];
    t_entry wdata;

    logic [31:0] in_key, fold;
    logic [SET_W-1:0] in_set;
    logic out_free, take;

    assign in_key = s_axis_tdata[33:2];
    assign fold   = in_key ^ (in_key >> 16);
    assign in_set = SET_W'(fold % NUM_SETS);

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign take          = s_axis_tvalid && s_axis_tready;

    genvar g;
    generate
        for (g = 0; g < NUM_WAYS; g++) begin : g_way
            tfst_way_ram u_ram (
                .i_clk  (i_clk),
                .i_we   (we[g]),
                .i_waddr(r_set),
                .i_wdata(wdata),
                .i_raddr(in_set),
                .o_rdata(rd[g])
            );
        end
    endgenerate

    // valid memory: registered read at the request's set
    always_ff @(posedge i_clk) begin
        if (vwe) begin
            r_vmem[vwaddr] <= vwdata;
        end
        r_vrd <= r_vmem[in_set];
    end

    // hit search and free way search
    logic [NUM_WAYS-1:0] vset;
    logic hit, has_free;
    logic [WAY_W-1:0] hway, fway;
    t_entry cur;

    always_comb begin
        vset = r_vrd;
        hit = 1'b0; hway = '0; has_free = 1'b0; fway = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (vset[w] && rd[w].key == r_key) begin
                hit = 1'b1; hway = WAY_W'(w);
            end
            if (!vset[w]) begin
                has_free = 1'b1; fway = WAY_W'(w);
            end
        end
        cur = rd[hway];
    end

    // update of a found flow, and the record for a new one
    t_entry upd, newe;
    logic [31:0] amend, probe;
    logic [7:0]  st;
    always_comb begin
        upd   = cur;
        amend = (r_len != 16'd0 || cur.last_len != 16'd0) ? {16'd0, cur.last_len} : 32'd1;
        probe = r_ack - amend;
        if (r_seq != cur.src_seq && r_seq != cur.dst_seq) begin
            if (probe == cur.src_seq) upd.dst_seq = r_seq;
            else if (probe == cur.dst_seq) upd.src_seq = r_seq;
        end
        st = cur.life;
        if ((r_fl & FL_RST) != 8'd0) st = st | 8'h10;
        else if (r_fl == FL_SYNACK) st = st | 8'h40;
        else if (cur.last_flags == FL_SYNACK && r_fl == FL_ACK) st = st | 8'h20;
        else if ((r_fl & FL_FIN) != 8'd0 && (r_fl & FL_ACK) != 8'd0)
            st = st | (st[3] ? 8'h02 : 8'h08);
        else if ((cur.last_flags & FL_FIN) != 8'd0 && (cur.last_flags & FL_ACK) != 8'd0
                 && r_fl == FL_ACK)
            st = st | (st[2] ? 8'h01 : 8'h04);
        upd.life       = st;
        upd.last_flags = r_fl;
        upd.last_len   = r_len;
        if (cur.hits != 32'hffff_ffff) upd.hits = cur.hits + 32'd1;

        newe.key = r_key; newe.src_seq = r_seq; newe.dst_seq = '0;
        newe.last_len = r_len; newe.last_flags = r_fl; newe.life = STATE_NEW;
        newe.hits = 32'd1;
    end

    // decision in the execute cycle
    logic [2:0]  n_status;
    logic [7:0]  n_fstate;
    logic [31:0] n_hits;
    logic do_write, do_create, do_delete;
    logic [WAY_W-1:0] wway;

    always_comb begin
        n_status = ST_NOTFOUND; n_fstate = '0; n_hits = '0;
        do_write = 1'b0; do_create = 1'b0; do_delete = 1'b0; wway = hway;
        wdata = upd;
        case (r_cmd)
            CMD_PACKET: begin
                if (hit) begin
                    n_status = ST_UPDATED; n_fstate = upd.life; n_hits = upd.hits;
                    do_write = 1'b1;
                end else if (r_fl != FL_SYN) begin
                    n_status = ST_IGNORED;
                end else if (has_free) begin
                    n_status = ST_CREATED; n_fstate = STATE_NEW; n_hits = 32'd1;
                    do_write = 1'b1; do_create = 1'b1; wway = fway; wdata = newe;
                end else begin
                    n_status = ST_FULL;
                end
            end
            CMD_QUERY: begin
                if (hit) begin
                    n_status = ST_FOUND; n_fstate = cur.life; n_hits = cur.hits;
                end
            end
            CMD_DELETE: begin
                if (hit) begin
                    n_status = ST_DELETED; do_delete = 1'b1;
                end
            end
            default: n_status = ST_NOTFOUND;
        endcase
        for (int w = 0; w < NUM_WAYS; w++) begin
            we[w] = (r_state == S_EXEC) && do_write && (wway == WAY_W'(w));
        end
    end

    // valid write-back: clearing pass, then create and delete
    always_comb begin
        vwe    = 1'b0;
        vwaddr = r_set;
        vwdata = r_vrd;
        if (r_state == S_CLEAR) begin
            vwe    = 1'b1;
            vwaddr = r_clr;
            vwdata = '0;
        end else if (r_state == S_EXEC && (do_create || do_delete)) begin
            vwe = 1'b1;
            if (do_create) vwdata[fway] = 1'b1;
            if (do_delete) vwdata[hway] = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == SET_W'(NUM_SETS - 1)) n_state = S_IDLE;
            S_IDLE:  if (take) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == S_EXEC) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
        end
    end

    // request capture and result register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= s_axis_tdata[1:0];
            r_key <= in_key;
            r_seq <= s_axis_tdata[65:34];
            r_ack <= s_axis_tdata[97:66];
            r_fl  <= s_axis_tdata[105:98];
            r_len <= s_axis_tdata[121:106];
            r_set <= in_set;
        end
        if (r_state == S_EXEC) begin
            m_axis_tdata <= {4'd0, n_hits,
                             (n_status <= ST_CREATED || n_status == ST_FOUND)
                                 && n_fstate >= PERFECT_MIN,
                             n_fstate, n_status};
        end
    end

endmodule
